// ===== design/dtls_pkg.sv =====
// ----------------------------------------------------------------------------
// dtls_pkg
// Shared types, constants and the dash pattern table of the dashed thick
// line stepper.
// ----------------------------------------------------------------------------
package dtls_pkg;

   // Screen and coordinate geometry
   localparam int COORD_BITS    = 12;
   localparam int PIXEL_BITS    = COORD_BITS + 1;
   localparam int DECISION_BITS = COORD_BITS + 4;
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;

   // Field widths
   localparam int THICK_BITS  = 8;
   localparam int STYLE_BITS  = 2;
   localparam int COLOR_BITS  = 32;
   localparam int OFFSET_BITS = THICK_BITS;
   localparam int DASH_BITS   = 4;
   localparam int CSR_BITS    = THICK_BITS;

   // Stream payload layout, padded to whole bytes
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * PIXEL_BITS + COLOR_BITS + 7) / 8) * 8;

   typedef logic signed [COORD_BITS-1:0]    coord_type;
   typedef logic signed [PIXEL_BITS-1:0]    pixel_type;
   typedef logic        [PIXEL_BITS-1:0]    delta_type;
   typedef logic signed [DECISION_BITS-1:0] decision_type;
   typedef logic signed [OFFSET_BITS-1:0]   offset_type;
   typedef logic signed [1:0]               step_type;
   typedef logic        [COLOR_BITS-1:0]    color_type;

   // Item kinds on the request channel
   typedef enum logic {
      FUNC_BEGIN = 1'b0,
      FUNC_STEP  = 1'b1
   } func_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_LINE_THICKNESS = 1'b0,
      CSR_DASH_STYLE     = 1'b1
   } csr_index_type;

   // Dash patterns: solid, dotted, dash-dot, dashed
   function automatic logic [15:0] dash_pattern(input logic [STYLE_BITS-1:0] style);
      logic [15:0] pat;
      case (style)
         2'd0:    pat = 16'hffff;
         2'd1:    pat = 16'h3333;
         2'd2:    pat = 16'h1e3f;
         2'd3:    pat = 16'h1f1f;
         default: pat = 16'hffff;
      endcase
      return pat;
   endfunction

endpackage

// ===== design/dashed_thick_line_stepper.sv =====
// ----------------------------------------------------------------------------
// dashed_thick_line_stepper
// Bresenham line generator with thickness and dash pattern, one candidate
// pixel per step item.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries items. tuser selects the kind: a begin item loads the
//   endpoints and pen colour from tdata and yields no result; a step item
//   yields exactly one result on rsp_*.
//   rsp_tdata holds the pixel position and colour, rsp_tuser the draw flag
//   (dash bit set and pixel on screen), rsp_tlast marks the final pixel of a
//   line, or a step taken while no line is active.
//   csr_* writes line thickness (index 0) and dash style (index 1); write
//   only while the block is idle.
// Timing and throughput:
//   A step item shows its result from the result register in the cycle
//   after it is accepted. One item is taken every cycle while the receiver
//   does not stall a held result; the Bresenham update (one compare and two
//   adds on the decision term) runs from the state registers back into them.
// Reset and stall:
//   Synchronous reset clears the line state (no line active), sets thickness
//   to 1 and style to solid, and empties the result register. While the
//   receiver stalls a held result, req_tready drops; it stays high when the
//   result register is empty or is being taken in the same cycle.
// ----------------------------------------------------------------------------
module dashed_thick_line_stepper (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: start_x, start_y, stop_x, stop_y, pen_color
   input  logic [dtls_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // tuser: func
   input  logic                                req_tuser,
   // Configuration port
   input  logic                                csr_we,
   input  logic                                csr_addr,
   input  logic [dtls_pkg::CSR_BITS-1:0]       csr_wdata,
   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: pixel_x, pixel_y, pixel_color, zero padding
   output logic [dtls_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // tuser: draw
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import dtls_pkg::*;

   localparam int SX_LO  = 0;
   localparam int SY_LO  = COORD_BITS;
   localparam int EX_LO  = 2 * COORD_BITS;
   localparam int EY_LO  = 3 * COORD_BITS;
   localparam int COL_LO = 4 * COORD_BITS;
   localparam int PAD_BITS = RSP_DATA_BITS - 2 * PIXEL_BITS - COLOR_BITS;
   localparam int DEC_PAD  = DECISION_BITS - PIXEL_BITS - 1;

   // Configuration registers
   logic [THICK_BITS-1:0] thick_ff;
   logic [STYLE_BITS-1:0] style_ff;

   // Line state
   pixel_type             cur_x_ff, cur_x_in;
   pixel_type             cur_y_ff, cur_y_in;
   coord_type             end_x_ff, end_x_in;
   coord_type             end_y_ff, end_y_in;
   step_type              step_x_ff, step_x_in;
   step_type              step_y_ff, step_y_in;
   delta_type             delta_x_ff, delta_x_in;
   delta_type             delta_y_ff, delta_y_in;
   decision_type          decision_ff, decision_in;
   logic                  x_major_ff, x_major_in;
   logic [DASH_BITS-1:0]  dash_index_ff, dash_index_in;
   offset_type            span_offset_ff, span_offset_in;
   logic                  active_ff, active_in;
   color_type             held_color_ff, held_color_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   pixel_type             rsp_x_ff, rsp_x_in;
   pixel_type             rsp_y_ff, rsp_y_in;
   color_type             rsp_color_ff, rsp_color_in;
   logic                  rsp_draw_ff, rsp_draw_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Request fields
   coord_type             start_x, start_y, stop_x, stop_y;
   color_type             pen_color;
   logic                  accept;

   // Begin set-up terms
   pixel_type             x0, y0, x1, y1, dx, dy;
   delta_type             adx, ady, dmin, dmax;
   logic                  begin_x_major;

   // Step terms
   offset_type            range, neg_range, off;
   pixel_type             off_ext, px, py;
   logic [15:0]           dash_pat;
   logic                  dash_bit, onscreen, span_end, at_end;
   delta_type             d_major, d_minor;
   decision_type          two_major, two_minor, dec_adj;
   logic                  dec_pos;
   pixel_type             sx_ext, sy_ext;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   // Unpack the request payload
   assign start_x   = coord_type'(req_tdata[SX_LO +: COORD_BITS]);
   assign start_y   = coord_type'(req_tdata[SY_LO +: COORD_BITS]);
   assign stop_x    = coord_type'(req_tdata[EX_LO +: COORD_BITS]);
   assign stop_y    = coord_type'(req_tdata[EY_LO +: COORD_BITS]);
   assign pen_color = req_tdata[COL_LO +: COLOR_BITS];

   // Begin: endpoint differences, magnitudes, major axis and the decision terms
   always_comb begin
      x0 = {start_x[COORD_BITS-1], start_x};
      y0 = {start_y[COORD_BITS-1], start_y};
      x1 = {stop_x[COORD_BITS-1], stop_x};
      y1 = {stop_y[COORD_BITS-1], stop_y};
      dx = x1 - x0;
      dy = y1 - y0;
      adx = dx[PIXEL_BITS-1] ? delta_type'(-dx) : delta_type'(dx);
      ady = dy[PIXEL_BITS-1] ? delta_type'(-dy) : delta_type'(dy);
      begin_x_major = (ady <= adx);
      dmin = begin_x_major ? ady : adx;
      dmax = begin_x_major ? adx : ady;
   end

   // Step: span offset, candidate pixel, dash bit and the Bresenham advance
   always_comb begin
      range     = offset_type'({1'b0, thick_ff[THICK_BITS-1:1]});
      neg_range = -range;
      off       = span_offset_ff;
      if (off < neg_range) begin
         off = neg_range;
      end
      if (off > range) begin
         off = range;
      end
      off_ext = {{(PIXEL_BITS-OFFSET_BITS){off[OFFSET_BITS-1]}}, off};
      px = x_major_ff ? cur_x_ff : cur_x_ff + off_ext;
      py = x_major_ff ? cur_y_ff + off_ext : cur_y_ff;

      dash_pat = dash_pattern(style_ff);
      dash_bit = dash_pat[~dash_index_ff];
      onscreen = (px >= 0) && (px < pixel_type'(SCREEN_WIDTH)) &&
                 (py >= 0) && (py < pixel_type'(SCREEN_HEIGHT));

      span_end = (off >= range);
      at_end   = x_major_ff ? (cur_x_ff == {end_x_ff[COORD_BITS-1], end_x_ff})
                            : (cur_y_ff == {end_y_ff[COORD_BITS-1], end_y_ff});

      d_major   = x_major_ff ? delta_x_ff : delta_y_ff;
      d_minor   = x_major_ff ? delta_y_ff : delta_x_ff;
      two_major = decision_type'({{DEC_PAD{1'b0}}, d_major, 1'b0});
      two_minor = decision_type'({{DEC_PAD{1'b0}}, d_minor, 1'b0});
      dec_pos   = !decision_ff[DECISION_BITS-1];
      dec_adj   = dec_pos ? decision_ff - two_major : decision_ff;

      sx_ext = {{(PIXEL_BITS-2){step_x_ff[1]}}, step_x_ff};
      sy_ext = {{(PIXEL_BITS-2){step_y_ff[1]}}, step_y_ff};
   end

   // Next state of the line and of the result register
   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      end_x_in       = end_x_ff;
      end_y_in       = end_y_ff;
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      delta_x_in     = delta_x_ff;
      delta_y_in     = delta_y_ff;
      decision_in    = decision_ff;
      x_major_in     = x_major_ff;
      dash_index_in  = dash_index_ff;
      span_offset_in = span_offset_ff;
      active_in      = active_ff;
      held_color_in  = held_color_ff;

      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_draw_in  = rsp_draw_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept && (func_type'(req_tuser) == FUNC_BEGIN)) begin
         // Load a new line, replacing any in progress
         step_x_in      = (dx == 0) ? 2'sd0 : (dx[PIXEL_BITS-1] ? -2'sd1 : 2'sd1);
         step_y_in      = (dy == 0) ? 2'sd0 : (dy[PIXEL_BITS-1] ? -2'sd1 : 2'sd1);
         delta_x_in     = adx;
         delta_y_in     = ady;
         cur_x_in       = x0;
         cur_y_in       = y0;
         end_x_in       = stop_x;
         end_y_in       = stop_y;
         x_major_in     = begin_x_major;
         decision_in    = decision_type'({{DEC_PAD{1'b0}}, dmin, 1'b0}) -
                          decision_type'({{(DECISION_BITS-PIXEL_BITS){1'b0}}, dmax});
         dash_index_in  = '0;
         span_offset_in = neg_range;
         held_color_in  = pen_color;
         active_in      = 1'b1;
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         if (!active_ff) begin
            // No line: empty pixel marked last
            rsp_x_in     = '0;
            rsp_y_in     = '0;
            rsp_color_in = '0;
            rsp_draw_in  = 1'b0;
            rsp_last_in  = 1'b1;
         end else begin
            rsp_x_in     = px;
            rsp_y_in     = py;
            rsp_color_in = held_color_ff;
            rsp_draw_in  = dash_bit && onscreen;
            rsp_last_in  = span_end && at_end;
            if (span_end) begin
               span_offset_in = neg_range;
               if (at_end) begin
                  active_in = 1'b0;
               end else begin
                  // Advance the major axis, and the minor one on a non-negative term
                  dash_index_in = dash_index_ff + DASH_BITS'(1);
                  decision_in   = dec_adj + two_minor;
                  if (x_major_ff) begin
                     cur_x_in = cur_x_ff + sx_ext;
                     if (dec_pos) begin
                        cur_y_in = cur_y_ff + sy_ext;
                     end
                  end else begin
                     cur_y_in = cur_y_ff + sy_ext;
                     if (dec_pos) begin
                        cur_x_in = cur_x_ff + sx_ext;
                     end
                  end
               end
            end else begin
               span_offset_in = off + offset_type'(1);
            end
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff <= THICK_BITS'(1);
         style_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_LINE_THICKNESS: thick_ff <= csr_wdata;
            CSR_DASH_STYLE:     style_ff <= csr_wdata[STYLE_BITS-1:0];
            default:            thick_ff <= thick_ff;
         endcase
      end
   end

   // Line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         end_x_ff       <= '0;
         end_y_ff       <= '0;
         step_x_ff      <= '0;
         step_y_ff      <= '0;
         delta_x_ff     <= '0;
         delta_y_ff     <= '0;
         decision_ff    <= '0;
         x_major_ff     <= 1'b0;
         dash_index_ff  <= '0;
         span_offset_ff <= '0;
         active_ff      <= 1'b0;
         held_color_ff  <= '0;
      end else begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         end_x_ff       <= end_x_in;
         end_y_ff       <= end_y_in;
         step_x_ff      <= step_x_in;
         step_y_ff      <= step_y_in;
         delta_x_ff     <= delta_x_in;
         delta_y_ff     <= delta_y_in;
         decision_ff    <= decision_in;
         x_major_ff     <= x_major_in;
         dash_index_ff  <= dash_index_in;
         span_offset_ff <= span_offset_in;
         active_ff      <= active_in;
         held_color_ff  <= held_color_in;
      end
   end

   // Result register: valid is cleared by reset, payload just follows
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_draw_ff  <= rsp_draw_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, rsp_color_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_draw_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/dtls_checker.sv =====
// ----------------------------------------------------------------------------
// dtls_checker
// Port-level checks of the dashed thick line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module dtls_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [dtls_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);
   import dtls_pkg::*;

   logic      req_take;
   logic      rsp_free;
   pixel_type chk_x, chk_y;

   assign req_take = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid || rsp_tready;
   assign chk_x    = pixel_type'(rsp_tdata[PIXEL_BITS-1:0]);
   assign chk_y    = pixel_type'(rsp_tdata[2*PIXEL_BITS-1:PIXEL_BITS]);

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A step item always yields a result in the next cycle
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_tuser == FUNC_STEP) |=> rsp_tvalid)
      else $error("step item gave no result");

   // A begin item yields no result
   a_begin_silent: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_tuser == FUNC_BEGIN) && rsp_free |=> !rsp_tvalid)
      else $error("begin item gave a result");

   // Draw is only flagged for pixels on screen
   a_draw_onscreen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (chk_x >= 0) && (chk_x < pixel_type'(SCREEN_WIDTH)) &&
                                  (chk_y >= 0) && (chk_y < pixel_type'(SCREEN_HEIGHT)))
      else $error("draw flagged off screen");

endmodule

bind dashed_thick_line_stepper dtls_checker u_dtls_checker (.*);
